// File: design/pra_pkg.sv
package pra_pkg;

	// Field widths of the stream beats and the tolerance register.
	localparam int CoordBits = 16;
	localparam int CountBits = 16;
	localparam int TolBits   = 32;

	// Beat widths, padded to whole bytes.
	localparam int InBits  = ((2 * CoordBits + CountBits + 7) / 8) * 8;
	localparam int OutBits = ((2 * CoordBits + 7) / 8) * 8;

	// Area arithmetic: edge vectors, their products and the doubled area.
	localparam int DiffBits = CoordBits + 1;
	localparam int ProdBits = 2 * DiffBits;
	localparam int AreaBits = ProdBits + 1;
	localparam int ThrBits  = TolBits + 1;
	localparam int CmpBits  = (AreaBits > ThrBits) ? AreaBits : ThrBits;

	// A polygon needs more than this many vertices to be reduced.
	localparam int MinCount = 3;

	// Result kinds carried on tuser.
	localparam int StatusBits = 2;
	localparam logic [StatusBits-1:0] StKept    = 2'd0;
	localparam logic [StatusBits-1:0] StDone    = 2'd1;
	localparam logic [StatusBits-1:0] StTooFew  = 2'd2;
	localparam logic [StatusBits-1:0] StTolHigh = 2'd3;

	// Result queue.
	localparam int QDepth    = 4;
	localparam int QAddrBits = $clog2(QDepth);
	localparam int QCntBits  = $clog2(QDepth + 1);

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic [CountBits-1:0] count_t;

	typedef struct packed {
		coord_t                 x;
		coord_t                 y;
		logic [StatusBits-1:0]  status;
		logic                   last;
	} result_t;

	// Twice the triangle area is the cross product of the edges (a - p) and
	// (n - p). True when its magnitude is above the doubled tolerance.
	function automatic logic area_exceeds(
		input coord_t ax, input coord_t ay,
		input coord_t px, input coord_t py,
		input coord_t nx, input coord_t ny,
		input logic [ThrBits-1:0] thr
	);
		logic signed [DiffBits-1:0] d_ax, d_ay, d_nx, d_ny;
		logic signed [ProdBits-1:0] m0, m1;
		logic signed [AreaBits-1:0] area;
		logic [AreaBits-1:0] mag;
		d_ax = DiffBits'(ax) - DiffBits'(px);
		d_ay = DiffBits'(ay) - DiffBits'(py);
		d_nx = DiffBits'(nx) - DiffBits'(px);
		d_ny = DiffBits'(ny) - DiffBits'(py);
		m0 = d_ax * d_ny;
		m1 = d_ay * d_nx;
		area = AreaBits'(m0) - AreaBits'(m1);
		mag = area[AreaBits-1] ? AreaBits'(-area) : AreaBits'(area);
		return CmpBits'(mag) > CmpBits'(thr);
	endfunction

endpackage

// File: design/polygon_reduce_by_area.sv
// An input beat is registered when it is accepted and is evaluated from that register; a result
// it causes is written to the result queue before it can be taken, and the closing beats of a
// normal polygon follow the wrap test, which runs after the final input beat.
// Throughput: one input beat per cycle while the four-entry result queue holds at most two
// entries and no wrap test is pending; a final beat that leads to the wrap test holds the input
// while that test runs; results leave at one per cycle while m_axis_tready is high.
// Reset (arst_n low, asynchronous): queue empty, no item held, tolerance 0, new polygon.
module polygon_reduce_by_area (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// point_x [15:0], point_y [31:16], vertex_count [47:32]
	input  logic [pra_pkg::InBits-1:0]   s_axis_tdata,

	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// out_x [15:0], out_y [31:16]
	output logic [pra_pkg::OutBits-1:0]  m_axis_tdata,
	// status [1:0]
	output logic [pra_pkg::StatusBits-1:0] m_axis_tuser,
	// last_of_polygon
	output logic                         m_axis_tlast,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pra_pkg::TolBits-1:0]  cfg_data
);

	localparam int Cb = pra_pkg::CoordBits;

	// Input stage: one registered beat waiting for the area unit.
	logic            valid_s1;
	pra_pkg::coord_t x_s1, y_s1;
	pra_pkg::count_t count_s1;

	// Polygon walk state. pos_q never exceeds the largest vertex count,
	// because it returns to zero as soon as it reaches the count.
	pra_pkg::count_t pos_q, pos_d;
	pra_pkg::coord_t anchor_x_q, anchor_y_q, anchor_x_d, anchor_y_d;
	pra_pkg::coord_t pend_x_q, pend_y_q, pend_x_d, pend_y_d;
	pra_pkg::coord_t first_x_q, first_y_q, first_x_d, first_y_d;
	logic            have_q, have_d;
	logic            wrap_q, wrap_d;
	logic [pra_pkg::TolBits-1:0] tol_q;

	// Result queue.
	pra_pkg::result_t               queue_q [pra_pkg::QDepth];
	logic [pra_pkg::QAddrBits-1:0]  wp_q, rp_q;
	logic [pra_pkg::QCntBits-1:0]   cnt_q;

	logic                 room, do_item, do_wrap, exceed, final_item, pop;
	pra_pkg::coord_t      n_x, n_y;
	pra_pkg::result_t     e0, e1, head;
	logic                 push0, push1;
	logic [1:0]           npush;

	// The user must change the tolerance only while the block is idle; the block does not enforce
	// this, and the write is always taken at once.
	assign cfg_ready = 1'b1;

	// The area unit is entered only while the queue can take the two results
	// that one evaluation can produce. The queue fill alone decides this, so
	// there is no path from m_axis_tready to s_axis_tready.
	assign room    = cnt_q <= pra_pkg::QCntBits'(pra_pkg::QDepth - 2);
	assign do_wrap = wrap_q && room;
	assign do_item = valid_s1 && !wrap_q && room;
	assign s_axis_tready = !valid_s1 || do_item;

	// The anchor and pending point are state in both kinds of test; only the
	// new point differs: the streamed one, or the first kept vertex on wrap.
	assign n_x = wrap_q ? first_x_q : x_s1;
	assign n_y = wrap_q ? first_y_q : y_s1;
	assign exceed = pra_pkg::area_exceeds(anchor_x_q, anchor_y_q, pend_x_q, pend_y_q,
		n_x, n_y, {tol_q, 1'b0});

	assign final_item = pos_q >= count_s1;

	always_comb begin
		pos_d      = pos_q;
		anchor_x_d = anchor_x_q;
		anchor_y_d = anchor_y_q;
		pend_x_d   = pend_x_q;
		pend_y_d   = pend_y_q;
		first_x_d  = first_x_q;
		first_y_d  = first_y_q;
		have_d     = have_q;
		wrap_d     = wrap_q;
		e0         = '0;
		e1         = '0;
		push0      = 1'b0;
		push1      = 1'b0;

		if (do_wrap) begin
			// Closing test with the first kept vertex as the new point,
			// then the done beat that ends the polygon.
			wrap_d = 1'b0;
			have_d = 1'b0;
			push0  = 1'b1;
			if (exceed) begin
				e0.x = pend_x_q;
				e0.y = pend_y_q;
				e0.status = pra_pkg::StKept;
				anchor_x_d = pend_x_q;
				anchor_y_d = pend_y_q;
				push1 = 1'b1;
				e1.status = pra_pkg::StDone;
				e1.last = 1'b1;
			end else begin
				e0.status = pra_pkg::StDone;
				e0.last = 1'b1;
			end
			pend_x_d = first_x_q;
			pend_y_d = first_y_q;
		end else if (do_item) begin
			if (count_s1 <= pra_pkg::CountBits'(pra_pkg::MinCount)) begin
				// Too few vertices: nothing until the final beat, which
				// reports the condition.
				if (final_item) begin
					push0 = 1'b1;
					e0.status = pra_pkg::StTooFew;
					e0.last = 1'b1;
					pos_d = '0;
					have_d = 1'b0;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end else if (pos_q == '0) begin
				anchor_x_d = x_s1;
				anchor_y_d = y_s1;
				have_d = 1'b0;
				pos_d = pra_pkg::CountBits'(1);
			end else if (pos_q == pra_pkg::CountBits'(1)) begin
				pend_x_d = x_s1;
				pend_y_d = y_s1;
				pos_d = pra_pkg::CountBits'(2);
			end else begin
				if (exceed) begin
					push0 = 1'b1;
					e0.x = pend_x_q;
					e0.y = pend_y_q;
					e0.status = pra_pkg::StKept;
					anchor_x_d = pend_x_q;
					anchor_y_d = pend_y_q;
					if (!have_q) begin
						first_x_d = pend_x_q;
						first_y_d = pend_y_q;
						have_d = 1'b1;
					end
				end
				pend_x_d = x_s1;
				pend_y_d = y_s1;
				if (!final_item) begin
					pos_d = pos_q + 1'b1;
				end else begin
					pos_d = '0;
					if (!(have_q || exceed)) begin
						// Nothing kept: the tolerance swallowed the polygon.
						push0 = 1'b1;
						e0.status = pra_pkg::StTolHigh;
						e0.last = 1'b1;
					end else begin
						wrap_d = 1'b1;
					end
				end
			end
		end
	end

	assign npush = {1'b0, push0} + {1'b0, push1};
	assign pop   = m_axis_tvalid && m_axis_tready;

	// The points reset to zero: a polygon whose vertex count changes part way
	// can reach the area test before its anchor and pending point were loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			pos_q      <= '0;
			have_q     <= 1'b0;
			wrap_q     <= 1'b0;
			tol_q      <= '0;
			wp_q       <= '0;
			rp_q       <= '0;
			cnt_q      <= '0;
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			pend_x_q   <= '0;
			pend_y_q   <= '0;
			first_x_q  <= '0;
			first_y_q  <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			pos_q  <= pos_d;
			have_q <= have_d;
			wrap_q <= wrap_d;
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			wp_q  <= wp_q + pra_pkg::QAddrBits'(npush);
			rp_q  <= rp_q + pra_pkg::QAddrBits'(pop);
			cnt_q <= cnt_q + pra_pkg::QCntBits'(npush) - pra_pkg::QCntBits'(pop);
			anchor_x_q <= anchor_x_d;
			anchor_y_q <= anchor_y_d;
			pend_x_q   <= pend_x_d;
			pend_y_q   <= pend_y_d;
			first_x_q  <= first_x_d;
			first_y_q  <= first_y_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			x_s1     <= s_axis_tdata[Cb-1:0];
			y_s1     <= s_axis_tdata[2*Cb-1:Cb];
			count_s1 <= s_axis_tdata[2*Cb+pra_pkg::CountBits-1:2*Cb];
		end
		if (push0) begin
			queue_q[wp_q] <= e0;
		end
		if (push1) begin
			queue_q[wp_q + pra_pkg::QAddrBits'(1)] <= e1;
		end
	end

	assign head          = queue_q[rp_q];
	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = pra_pkg::OutBits'({head.y, head.x});
	assign m_axis_tuser  = head.status;
	assign m_axis_tlast  = head.last;

endmodule

// File: design/pra_checker.sv
module pra_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [pra_pkg::OutBits-1:0]    m_axis_tdata,
	input logic [pra_pkg::StatusBits-1:0] m_axis_tuser,
	input logic                           m_axis_tlast
);

	// A kept vertex never closes a polygon.
	a_kept_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == pra_pkg::StKept |-> !m_axis_tlast)
		else $error("kept vertex beat marked last");

	// Every status beat closes its polygon and carries no coordinates.
	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != pra_pkg::StKept |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("status beat not last or with coordinates");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result beat changed");

endmodule

bind polygon_reduce_by_area pra_checker u_pra_checker (.*);
